/* rtl/a256c_pkg.sv */
// Shared types, constants and helper functions for the AES-256 CFB128 byte-stream unit.
package a256c_pkg;

  // Number of AES-256 rounds after the initial key whitening.
  localparam int NumRounds = 14;
  localparam int RndW      = 4;

  // Configuration port geometry.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_WORD_3 = 3'd3;

  // Op codes of an input transfer.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Cipher state: byte i of the block is element i.
  typedef logic [15:0][7:0] block_t;
  // Key schedule window: eight consecutive 32-bit schedule words, oldest first.
  typedef logic [7:0][31:0] kwin_t;

  // Reset value of both feedback registers: Fibonacci numbers mod 256.
  localparam block_t FIB_INIT = {8'hdb, 8'h62, 8'h79, 8'he9, 8'h90, 8'h59, 8'h37, 8'h22,
                                 8'h15, 8'h0d, 8'h08, 8'h05, 8'h03, 8'h02, 8'h01, 8'h01};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input transfer
    logic load;     // start a block: whitening and key window init
    logic round;    // run one AES round
    logic last;     // the round is the final one
    logic emit;     // produce the output byte and update the stream
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic enc_off_zero;
    logic dec_off_zero;
  } sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // Multiplication by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // XOR the round key held in the low four window words into the state.
  function automatic block_t add_round_key(input block_t s, input kwin_t w);
    block_t r;
    r = s;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        r[4*c+j] = s[4*c+j] ^ w[c][31-8*j -: 8];
      end
    end
    return r;
  endfunction

  // Advance the key window by four schedule words.
  function automatic kwin_t key_step(input kwin_t w, input logic rot, input logic [7:0] rcon);
    kwin_t      r;
    logic [31:0] f;
    if (rot) begin
      f = sub_word({w[7][23:0], w[7][31:24]}) ^ {rcon, 24'h000000};
    end else begin
      f = sub_word(w[7]);
    end
    r[0] = w[4];
    r[1] = w[5];
    r[2] = w[6];
    r[3] = w[7];
    r[4] = w[0] ^ f;
    r[5] = w[1] ^ w[0] ^ f;
    r[6] = w[2] ^ w[1] ^ w[0] ^ f;
    r[7] = w[3] ^ w[2] ^ w[1] ^ w[0] ^ f;
    return r;
  endfunction

  // One AES round: SubBytes, ShiftRows, MixColumns (skipped in the final round).
  function automatic block_t aes_round(input block_t s, input logic last);
    block_t sb;
    block_t sr;
    block_t mc;
    logic [7:0] a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[s[i]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[r+4*c] = sb[r+4*((c+r)%4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sr[4*c];
      a1 = sr[4*c+1];
      a2 = sr[4*c+2];
      a3 = sr[4*c+3];
      mc[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      mc[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      mc[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      mc[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return last ? sr : mc;
  endfunction

endpackage

/* rtl/a256c_ctrl.sv */
// Controller state machine: sequences block encryption and byte output.
module a256c_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            op_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  a256c_pkg::sts_t sts_i,
  output a256c_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_EMIT
  } state_e;

  state_e                       state_q;
  logic [a256c_pkg::RndW-1:0]   rnd_q;
  logic                         out_valid_q;
  logic                         off_zero;

  // Offset of the stream that the incoming byte selects.
  assign off_zero = (op_i == a256c_pkg::OP_DECRYPT) ? sts_i.dec_off_zero : sts_i.enc_off_zero;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Command decode.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        cmd_o.load    = in_valid_i & off_zero;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        cmd_o.last  = (rnd_q == a256c_pkg::RndW'(a256c_pkg::NumRounds));
      end
      S_EMIT: begin
        cmd_o.emit = ~out_valid_q | out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State, round counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (off_zero) begin
              rnd_q   <= a256c_pkg::RndW'(1);
              state_q <= S_ROUND;
            end else begin
              state_q <= S_EMIT;
            end
          end
        end
        S_ROUND: begin
          if (cmd_o.last) begin
            state_q <= S_EMIT;
          end else begin
            rnd_q <= rnd_q + a256c_pkg::RndW'(1);
          end
        end
        S_EMIT: begin
          if (cmd_o.emit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/a256c_datapath.sv */
// Datapath: key registers, iterative AES round unit, feedback streams and output register.
module a256c_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  a256c_pkg::cmd_t                cmd_i,
  output a256c_pkg::sts_t                sts_o,
  input  logic                           cfg_we_i,
  input  logic [a256c_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [a256c_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           op_i,
  input  logic [7:0]                     data_in_i,
  input  logic                           end_of_message_i,
  output logic [7:0]                     data_out_o,
  output logic                           last_out_o
);

  logic [3:0][63:0]     key_q;
  a256c_pkg::kwin_t     key_win;
  a256c_pkg::kwin_t     win_q, win_d;
  logic [7:0]           rcon_q, rcon_d;
  logic                 kphase_q, kphase_d;
  a256c_pkg::block_t    state_q, state_d;
  a256c_pkg::block_t    round_out;
  a256c_pkg::block_t    enc_fb_q, enc_fb_d;
  a256c_pkg::block_t    dec_fb_q, dec_fb_d;
  logic [3:0]           enc_off_q, enc_off_d;
  logic [3:0]           dec_off_q, dec_off_d;
  logic                 op_q;
  logic [7:0]           data_q;
  logic                 eom_q;
  logic [7:0]           data_out_q;
  logic                 last_out_q;
  logic [3:0]           sel_off;
  logic [7:0]           ks_byte;
  logic [7:0]           res_byte;

  assign sts_o.enc_off_zero = (enc_off_q == 4'd0);
  assign sts_o.dec_off_zero = (dec_off_q == 4'd0);

  // Key bytes arranged as the first eight schedule words, first byte in the msb.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 4; j++) begin
        key_win[i][31-8*j -: 8] = key_q[(4*i+j)/8][8*((4*i+j)%8) +: 8];
      end
    end
  end

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        a256c_pkg::CFG_KEY_WORD_0: key_q[0] <= cfg_data_i;
        a256c_pkg::CFG_KEY_WORD_1: key_q[1] <= cfg_data_i;
        a256c_pkg::CFG_KEY_WORD_2: key_q[2] <= cfg_data_i;
        a256c_pkg::CFG_KEY_WORD_3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign round_out = a256c_pkg::add_round_key(a256c_pkg::aes_round(state_q, cmd_i.last), win_q);

  // Round unit and on-the-fly key schedule.
  always_comb begin
    state_d  = state_q;
    win_d    = win_q;
    rcon_d   = rcon_q;
    kphase_d = kphase_q;
    if (cmd_i.load) begin
      state_d  = a256c_pkg::add_round_key(
                   (op_i == a256c_pkg::OP_DECRYPT) ? dec_fb_q : enc_fb_q, key_win);
      win_d    = a256c_pkg::key_step(key_win, 1'b1, 8'h01);
      rcon_d   = 8'h02;
      kphase_d = 1'b1;
    end else if (cmd_i.round) begin
      state_d  = round_out;
      win_d    = a256c_pkg::key_step(win_q, ~kphase_q, rcon_q);
      kphase_d = ~kphase_q;
      if (!kphase_q) begin
        rcon_d = a256c_pkg::xtime(rcon_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    state_q  <= state_d;
    win_q    <= win_d;
    rcon_q   <= rcon_d;
    kphase_q <= kphase_d;
  end

  // Keystream byte and result of the captured transfer.
  assign sel_off  = op_q ? dec_off_q : enc_off_q;
  assign ks_byte  = op_q ? dec_fb_q[sel_off] : enc_fb_q[sel_off];
  assign res_byte = data_q ^ ks_byte;

  // Feedback registers and offsets.
  always_comb begin
    enc_fb_d  = enc_fb_q;
    dec_fb_d  = dec_fb_q;
    enc_off_d = enc_off_q;
    dec_off_d = dec_off_q;
    if (cmd_i.round && cmd_i.last) begin
      if (op_q) begin
        dec_fb_d = round_out;
      end else begin
        enc_fb_d = round_out;
      end
    end
    if (cmd_i.emit) begin
      if (op_q) begin
        dec_fb_d[sel_off] = data_q;
        dec_off_d         = dec_off_q + 4'd1;
      end else begin
        enc_fb_d[sel_off] = res_byte;
        enc_off_d         = enc_off_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_fb_q  <= a256c_pkg::FIB_INIT;
      dec_fb_q  <= a256c_pkg::FIB_INIT;
      enc_off_q <= 4'd0;
      dec_off_q <= 4'd0;
    end else begin
      enc_fb_q  <= enc_fb_d;
      dec_fb_q  <= dec_fb_d;
      enc_off_q <= enc_off_d;
      dec_off_q <= dec_off_d;
    end
  end

  // Input capture and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      data_q <= data_in_i;
      eom_q  <= end_of_message_i;
    end
    if (cmd_i.emit) begin
      data_out_q <= res_byte;
      last_out_q <= eom_q;
    end
  end

  assign data_out_o = data_out_q;
  assign last_out_o = last_out_q;

endmodule

/* rtl/aes256_cfb128_byte_stream_unit.sv */
// Top level of the AES-256 CFB128 byte-stream cipher.
// Each byte is captured on its input transfer and emitted through the output register; when
// the stream's offset is zero a new block is computed first (whitening in the accept cycle,
// fourteen rounds of the single AES round unit, output), at the start of each 16-byte block.
// A new byte is accepted only once the previous one has been emitted.
// Reset: both feedback registers load the Fibonacci pattern, offsets and key clear to zero.
module aes256_cfb128_byte_stream_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [a256c_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [a256c_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [7:0]                     data_in_i,
  input  logic                           end_of_message_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     data_out_o,
  output logic                           last_out_o
);

  a256c_pkg::cmd_t cmd;
  a256c_pkg::sts_t sts;

  // Sequencer.
  a256c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Cipher datapath.
  a256c_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .data_in_i        (data_in_i),
    .end_of_message_i (end_of_message_i),
    .data_out_o       (data_out_o),
    .last_out_o       (last_out_o)
  );

endmodule
